// ===== rtl/core/ptil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptil_pkg
// Shared constants, codes and types of the prefix tree insert/lookup core.
// ----------------------------------------------------------------------------
package ptil_pkg;

  localparam int POOL_NODES    = 1024;
  localparam int ALPHABET_SIZE = 26;

  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int FREE_W     = $clog2(POOL_NODES + 1);
  localparam int LINK_DEPTH = POOL_NODES * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int OP_W       = 2;
  localparam int LETTER_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_FIN,
    S_MARK
  } walk_state_t;

  typedef struct packed {
    logic               en;
    logic [LINK_AW-1:0] addr;
    logic [NODE_W-1:0]  data;
  } link_wr_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic              data;
  } mark_wr_t;

  typedef struct packed {
    logic valid;
    logic found;
    logic pool_full;
  } res_t;

endpackage

// ===== rtl/core/ptil_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptil_if
// Valid/ready channels for letter words and result words.
// ----------------------------------------------------------------------------
interface ptil_in_if;
  import ptil_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [LETTER_W-1:0] letter;
  logic                no_letter;
  logic                last_letter;

  modport source (output valid, opcode, letter, no_letter, last_letter, input ready);
  modport sink   (input valid, opcode, letter, no_letter, last_letter, output ready);
endinterface

interface ptil_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pool_full;

  modport source (output valid, found, pool_full, input ready);
  modport sink   (input valid, found, pool_full, output ready);
endinterface

// ===== rtl/core/ptil_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptil_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptil_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ptil_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptil_walk
// Cursor walk sequencer: clear sweep, link read/update, node allocation and
// word-end handling.
// ----------------------------------------------------------------------------
module ptil_walk (
  input  logic                          clk,
  input  logic                          rst,
  ptil_in_if.sink                       req,
  output ptil_pkg::link_wr_t            link_wr,
  output logic [ptil_pkg::LINK_AW-1:0]  link_raddr,
  input  logic [ptil_pkg::NODE_W-1:0]   link_rdata,
  output ptil_pkg::mark_wr_t            mark_wr,
  output logic [ptil_pkg::NODE_W-1:0]   mark_raddr,
  input  logic                          mark_rdata,
  input  logic                          slot_free,
  output ptil_pkg::res_t                res
);
  import ptil_pkg::*;

  walk_state_t        state, state_next;
  logic [NODE_W-1:0]  cursor, cursor_next;
  logic               missed, missed_next;
  logic               overflow, overflow_next;
  logic [FREE_W-1:0]  next_free, next_free_next;
  logic [LINK_AW-1:0] clr, clr_next;
  logic [OP_W-1:0]    op, op_next;
  logic               last, last_next;
  logic [LINK_AW-1:0] slot, slot_next;
  logic               stopped;

  assign link_raddr = LINK_AW'(cursor) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(req.letter);
  assign mark_raddr = cursor;
  assign stopped    = missed | overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cursor    <= '0;
      missed    <= 1'b0;
      overflow  <= 1'b0;
      next_free <= FREE_W'(1);
      clr       <= '0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      missed    <= missed_next;
      overflow  <= overflow_next;
      next_free <= next_free_next;
      clr       <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    last <= last_next;
    slot <= slot_next;
  end

  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    missed_next    = missed;
    overflow_next  = overflow;
    next_free_next = next_free;
    clr_next       = clr;
    op_next        = op;
    last_next      = last;
    slot_next      = slot;
    req.ready      = 1'b0;
    link_wr        = '0;
    mark_wr        = '0;
    res            = '0;

    unique case (state)
      S_CLEAR: begin
        link_wr.en   = 1'b1;
        link_wr.addr = clr;
        mark_wr.en   = (clr < LINK_AW'(POOL_NODES));
        mark_wr.addr = clr[NODE_W-1:0];
        if (clr == LINK_AW'(LINK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr + LINK_AW'(1);
        end
      end

      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next   = req.opcode;
          last_next = req.last_letter | req.no_letter;
          slot_next = link_raddr;
          priority if (req.no_letter) begin
            state_next = S_FIN;
          end else if (stopped) begin
            state_next = req.last_letter ? S_FIN : S_IDLE;
          end else if (req.letter >= LETTER_W'(ALPHABET_SIZE)) begin
            missed_next = 1'b1;
            state_next  = req.last_letter ? S_FIN : S_IDLE;
          end else begin
            state_next = S_LINK;
          end
        end
      end

      S_LINK: begin
        state_next = last ? S_FIN : S_IDLE;
        priority if (link_rdata != '0) begin
          cursor_next = link_rdata;
        end else if (op != OP_INSERT) begin
          missed_next = 1'b1;
        end else if (next_free >= FREE_W'(POOL_NODES)) begin
          overflow_next = 1'b1;
        end else begin
          link_wr.en     = 1'b1;
          link_wr.addr   = slot;
          link_wr.data   = next_free[NODE_W-1:0];
          cursor_next    = next_free[NODE_W-1:0];
          next_free_next = next_free + FREE_W'(1);
        end
      end

      S_FIN: begin
        if (op == OP_SEARCH && !stopped) begin
          state_next = S_MARK;
        end else if (slot_free) begin
          res.valid     = 1'b1;
          res.found     = (op != OP_SEARCH) && !stopped;
          res.pool_full = (op == OP_INSERT) && overflow;
          mark_wr.en    = (op == OP_INSERT) && !stopped;
          mark_wr.addr  = cursor;
          mark_wr.data  = 1'b1;
          cursor_next   = '0;
          missed_next   = 1'b0;
          overflow_next = 1'b0;
          state_next    = S_IDLE;
        end
      end

      S_MARK: begin
        if (slot_free) begin
          res.valid     = 1'b1;
          res.found     = mark_rdata;
          cursor_next   = '0;
          missed_next   = 1'b0;
          overflow_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/prefix_tree_insert_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_tree_insert_lookup_core
// 26-letter prefix tree in a 1024-node pool: insert, exact search, prefix test.
// ----------------------------------------------------------------------------
// After reset the core sweeps the link and word-end memories to zero, one link
// entry per cycle, with req.ready low. Words then arrive one letter per req
// word; a letter that walks a link first reads the child-link RAM, then
// updates the cursor or allocates a node. The last word of an entry then
// posts the result; an exact search whose walk has not stopped first reads
// the word-end RAM at the final node. An item whose walk is already stopped,
// or with an out-of-range letter, skips the link read.
// One result word per completed entry is held in an output register until
// taken; the next result waits for that register to free up.
module prefix_tree_insert_lookup_core (
  input logic      clk,
  input logic      rst,
  ptil_in_if.sink  req,
  ptil_out_if.source rsp
);
  import ptil_pkg::*;

  link_wr_t           link_wr;
  logic [LINK_AW-1:0] link_raddr;
  logic [NODE_W-1:0]  link_rdata;
  mark_wr_t           mark_wr;
  logic [NODE_W-1:0]  mark_raddr;
  logic               mark_rdata;
  res_t               res;
  logic               slot_free;
  logic               out_valid;
  logic               out_found;
  logic               out_full;

  ptil_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.en),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ptil_ram #(
    .WIDTH (1),
    .DEPTH (POOL_NODES)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_wr.en),
    .waddr (mark_wr.addr),
    .wdata (mark_wr.data),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  ptil_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .link_wr    (link_wr),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .mark_wr    (mark_wr),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata),
    .slot_free  (slot_free),
    .res        (res)
  );

  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_found <= res.found;
      out_full  <= res.pool_full;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.found     = out_found;
  assign rsp.pool_full = out_full;

endmodule
